// ===== rtl/hpf_pkg.sv =====
// Shared constants, widths and input codes for the histogram percentile finder.
package hpf_pkg;

	localparam int MAX_BINS    = 256;
	localparam int MAX_QUERIES = 16;
	localparam int WEIGHT_BITS = 16;

	// Fixed field widths of the item and result channels
	localparam int KIND_W   = 2;
	localparam int WGT_IN_W = 16;
	localparam int QF_W     = 17;
	localparam int VAL_W    = 32;
	localparam int RANK_W   = 4;
	localparam int FRAC_W   = 16;

	// Derived storage widths
	localparam int WT_W     = (WEIGHT_BITS < WGT_IN_W) ? WEIGHT_BITS : WGT_IN_W;
	localparam int BIN_AW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int BIN_CW   = $clog2(MAX_BINS + 1);
	localparam int Q_IW     = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
	localparam int Q_CW     = $clog2(MAX_QUERIES + 1);
	localparam int TOTAL_W  = $clog2(((2 ** WT_W) - 1) * MAX_BINS + 1);
	localparam int PROD_W   = QF_W + TOTAL_W;

	localparam logic [QF_W-1:0]  ONE_Q16 = QF_W'(65536);
	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	typedef enum logic [KIND_W-1:0] {
		KIND_BIN   = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_RUN   = 2'd2
	} kind_t;

endpackage

// ===== rtl/hpf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hpf_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/histogram_percentile_finder.sv =====
// Histogram percentile finder: loads bin weights and queries, answers each query on a run.
//
// Feed items on the item channel: kind 0 appends one bin weight (low WEIGHT_BITS bits,
// unsigned Q0.16) to the histogram, kind 1 inserts one percentile query (Q1.16, values
// above 1.0 saturate to 1.0) into a sorted query list, kind 2 starts a run, kind 3 is
// ignored. Loads transfer back to back. A load with no room left (MAX_BINS bins or
// MAX_QUERIES queries) is dropped and sets a sticky overflow flag that rides on every
// result of the next run. A run walks the bins from index 0 while keeping a running
// cumulative weight; a query q is reached at the first bin where cum * 65536 >= q *
// total weight, all in exact integers. For each query, in ascending order, one result
// transfers: result_value = bin index + value_offset (saturated to the signed 32-bit
// range), query_rank = its position, last marks the final one. A run with no bins or no
// queries gives no result. Every run ends with all counts, the total and the overflow
// flag cleared; value_offset is kept and may be written only while idle. Bin weights
// live in a RAM with registered read data, so each bin walked takes a read, an
// accumulate, a multiply of the current query by the total and a compare, and each
// answered query after the first takes one multiply and one compare; the result
// channel can stall the walk. The item channel stalls for the whole run. Nothing needs
// clearing after reset.
module histogram_percentile_finder
	import hpf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                item_valid,
	output logic                item_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [WGT_IN_W-1:0] bin_weight,
	input  logic [QF_W-1:0]     query_fraction,

	output logic                result_valid,
	input  logic                result_stall,
	output logic [VAL_W-1:0]    result_value,
	output logic [RANK_W-1:0]   query_rank,
	output logic                overflowed,
	output logic                last,

	input  logic                cfg_write_en,
	input  logic [VAL_W-1:0]    cfg_write_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_ADD,
		S_PROD,
		S_CHK
	} state_t;

	state_t               state_q;
	logic [VAL_W-1:0]     value_offset_q;
	logic [BIN_CW-1:0]    bin_cnt_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [Q_CW-1:0]      q_cnt_q;
	logic                 drop_q;
	logic [QF_W-1:0]      query_q [MAX_QUERIES];
	logic [QF_W-1:0]      query_nx [MAX_QUERIES];
	logic [MAX_QUERIES-1:0] q_gt;

	logic [BIN_AW-1:0]    idx_q;
	logic [Q_IW-1:0]      k_q;
	logic [TOTAL_W-1:0]   cum_q;
	logic [PROD_W-1:0]    prod_q;

	logic                 result_valid_q;
	logic [VAL_W-1:0]     result_value_q;
	logic [RANK_W-1:0]    query_rank_q;
	logic                 overflowed_q;
	logic                 last_q;

	logic                 item_xfer;
	logic                 bin_room;
	logic                 q_room;
	logic                 bin_we;
	logic [WT_W-1:0]      wgt;
	logic [QF_W-1:0]      q_sat;
	logic [WT_W-1:0]      bin_rdata;
	logic                 hit;
	logic                 can_emit;
	logic                 final_q;
	logic [VAL_W:0]       val_sum;
	logic [VAL_W-1:0]     val_sat;

	assign item_stall = (state_q != S_IDLE);
	assign item_xfer  = item_valid && !item_stall;
	assign bin_room   = (bin_cnt_q < BIN_CW'(MAX_BINS));
	assign q_room     = (q_cnt_q < Q_CW'(MAX_QUERIES));
	assign wgt        = bin_weight[WT_W-1:0];
	assign q_sat      = (query_fraction > ONE_Q16) ? ONE_Q16 : query_fraction;
	assign bin_we     = item_xfer && (kind == KIND_BIN) && bin_room;

	hpf_ram #(
		.DATA_W (WT_W),
		.DEPTH  (MAX_BINS)
	) u_bin_ram (
		.clk   (clk),
		.we    (bin_we),
		.waddr (bin_cnt_q[BIN_AW-1:0]),
		.wdata (wgt),
		.re    (state_q == S_READ),
		.raddr (idx_q),
		.rdata (bin_rdata)
	);

	// Sorted insert: entries above the new query move up one slot in parallel.
	always_comb begin
		for (int j = 0; j < MAX_QUERIES; j++) begin
			q_gt[j]     = (query_q[j] > q_sat);
			query_nx[j] = query_q[j];
		end
		if ((q_cnt_q == '0) || q_gt[0]) begin
			query_nx[0] = q_sat;
		end
		for (int j = 1; j < MAX_QUERIES; j++) begin
			if ((Q_CW'(j) == q_cnt_q) || ((Q_CW'(j) < q_cnt_q) && q_gt[j])) begin
				query_nx[j] = q_gt[j-1] ? query_q[j-1] : q_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer && (kind == KIND_QUERY) && q_room) begin
			query_q <= query_nx;
		end
	end

	// Reached when cum * 2^16 >= q * total
	assign hit      = (PROD_W'({cum_q, {FRAC_W{1'b0}}}) >= prod_q);
	assign can_emit = !result_valid_q || !result_stall;
	assign final_q  = ((Q_CW'(k_q) + Q_CW'(1)) == q_cnt_q);

	// Bin index is never negative, so only the upper limit can be crossed.
	assign val_sum = {value_offset_q[VAL_W-1], value_offset_q} + (VAL_W+1)'(idx_q);
	assign val_sat = (val_sum[VAL_W] != val_sum[VAL_W-1]) ? VAL_MAX : val_sum[VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			value_offset_q <= '0;
			bin_cnt_q      <= '0;
			total_q        <= '0;
			q_cnt_q        <= '0;
			drop_q         <= 1'b0;
			idx_q          <= '0;
			k_q            <= '0;
			cum_q          <= '0;
			prod_q         <= '0;
			result_valid_q <= 1'b0;
			result_value_q <= '0;
			query_rank_q   <= '0;
			overflowed_q   <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			// Drop the result once it transfers; CHK may refill it below.
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_write_en) begin
				value_offset_q <= cfg_write_data;
			end
			case (state_q)
				S_IDLE: begin
					if (item_xfer) begin
						case (kind)
							KIND_BIN: begin
								if (bin_room) begin
									bin_cnt_q <= bin_cnt_q + BIN_CW'(1);
									total_q   <= total_q + TOTAL_W'(wgt);
								end else begin
									drop_q <= 1'b1;
								end
							end
							KIND_QUERY: begin
								if (q_room) begin
									q_cnt_q <= q_cnt_q + Q_CW'(1);
								end else begin
									drop_q <= 1'b1;
								end
							end
							KIND_RUN: begin
								if ((bin_cnt_q == '0) || (q_cnt_q == '0)) begin
									bin_cnt_q <= '0;
									total_q   <= '0;
									q_cnt_q   <= '0;
									drop_q    <= 1'b0;
								end else begin
									idx_q   <= '0;
									k_q     <= '0;
									cum_q   <= '0;
									state_q <= S_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					cum_q   <= cum_q + TOTAL_W'(bin_rdata);
					state_q <= S_PROD;
				end
				S_PROD: begin
					prod_q  <= PROD_W'(query_q[k_q]) * PROD_W'(total_q);
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (!hit) begin
						// The last bin always reaches every query, so idx stays in range.
						idx_q   <= idx_q + BIN_AW'(1);
						state_q <= S_READ;
					end else if (can_emit) begin
						result_valid_q <= 1'b1;
						result_value_q <= val_sat;
						query_rank_q   <= RANK_W'(k_q);
						overflowed_q   <= drop_q;
						last_q         <= final_q;
						if (final_q) begin
							bin_cnt_q <= '0;
							total_q   <= '0;
							q_cnt_q   <= '0;
							drop_q    <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							k_q     <= k_q + Q_IW'(1);
							state_q <= S_PROD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result_value = result_value_q;
	assign query_rank   = query_rank_q;
	assign overflowed   = overflowed_q;
	assign last         = last_q;

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) |-> (Q_CW'(k_q) < q_cnt_q))
		else $error("query index beyond loaded queries");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD) |-> (BIN_CW'(idx_q) < bin_cnt_q))
		else $error("bin walk beyond loaded bins");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_CHK) && hit && can_emit && final_q) |=>
		((state_q == S_IDLE) && (bin_cnt_q == '0) && (q_cnt_q == '0) && !drop_q))
		else $error("run end did not clear the stores");

	a_total_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(bin_cnt_q == '0) |-> (total_q == '0))
		else $error("weight total nonzero with no bins");

endmodule

// ===== test/histogram_percentile_finder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the histogram percentile finder: directed table, then random sessions.
module histogram_percentile_finder_tb;
	import hpf_pkg::*;

	// Item code that the block has no use for; it must be swallowed silently.
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	// A run may end without any result, so before touching the offset register
	// wait out the longest walk the block can do, with some margin.
	localparam int SETTLE_CYCLES = 4 * MAX_BINS + 2 * MAX_QUERIES + 16;
	localparam int PHASE_ITEMS   = 50;
	localparam int NUM_PHASES    = 4;
	localparam int NUM_DIRECTED  = 22;
	localparam int PEND_DEPTH    = 64;

	// How a table row is checked: by the quantile predictor, or against a result
	// typed into the row (none, or exactly one).
	localparam int CHECK_PREDICTED = -1;
	localparam int CHECK_NONE      = 0;
	localparam int CHECK_ONE       = 1;

	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [RANK_W-1:0] rank;
		logic              ovf;
		logic              last;
	} answer_t;

	typedef struct packed {
		logic [KIND_W-1:0]   op;
		logic [WGT_IN_W-1:0] weight;
		logic [QF_W-1:0]     frac;
		int                  check;
		answer_t             want;
	} step_t;

	logic                clk;
	logic                arst_n         = 1'b0;
	logic                item_valid     = 1'b0;
	logic                item_stall;
	logic [KIND_W-1:0]   kind           = KIND_BIN;
	logic [WGT_IN_W-1:0] bin_weight     = '0;
	logic [QF_W-1:0]     query_fraction = '0;
	logic                result_valid;
	logic                result_stall   = 1'b0;
	logic [VAL_W-1:0]    result_value;
	logic [RANK_W-1:0]   query_rank;
	logic                overflowed;
	logic                last;
	logic                cfg_write_en   = 1'b0;
	logic [VAL_W-1:0]    cfg_write_data = '0;

	// Pause rates, in percent of cycles, for the current phase.
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;

	// Mirror of the block's state, kept by the quantile predictor.
	logic [VAL_W-1:0] offset_m = '0;
	logic [WT_W-1:0]  bins_m [MAX_BINS];
	int unsigned      nbins_m = 0;
	longint unsigned  total_m = 0;
	logic [QF_W-1:0]  queries_m [MAX_QUERIES];
	int unsigned      nq_m = 0;
	bit               dropped_m = 1'b0;

	answer_t fresh_answers [MAX_QUERIES];  // answers produced by the latest transfer
	int      fresh_count = 0;
	answer_t pending_answers [PEND_DEPTH]; // answers still owed by the block, as a ring
	int      pend_wr = 0;
	int      pend_rd = 0;
	answer_t head;

	int fail_count   = 0;
	int items_sent   = 0;
	int spare_sent   = 0;
	int runs_sent    = 0;
	int answers_seen = 0;
	int offsets_used = 0;

	// Directed part, all at the reset offset of zero. Rows whose answer is plain
	// to see carry it; the rest are left to the predictor.
	step_t directed_steps [NUM_DIRECTED] = '{
		// run with nothing loaded: no answer
		'{KIND_RUN,   16'h0000, 17'h00000, CHECK_NONE,      '0},
		// zero total weight: the query lands on bin zero
		'{KIND_BIN,   16'h0000, 17'h00000, CHECK_PREDICTED, '0},
		'{KIND_QUERY, 16'h0000, 17'h00000, CHECK_PREDICTED, '0},
		'{KIND_RUN,   16'h0000, 17'h00000, CHECK_ONE,       '{32'h0, 4'd0, 1'b0, 1'b1}},
		// unused code with every payload bit high: ignored
		'{KIND_SPARE, 16'hFFFF, 17'h1FFFF, CHECK_NONE,      '0},
		// full-scale weight, then a query above one that clamps to one
		'{KIND_BIN,   16'hFFFF, 17'h00000, CHECK_PREDICTED, '0},
		'{KIND_BIN,   16'h0001, 17'h00000, CHECK_PREDICTED, '0},
		'{KIND_QUERY, 16'h0000, 17'h1FFFF, CHECK_PREDICTED, '0},
		'{KIND_RUN,   16'h0000, 17'h00000, CHECK_ONE,       '{32'h1, 4'd0, 1'b0, 1'b1}},
		// queries without bins: no answer
		'{KIND_QUERY, 16'h0000, 17'h08000, CHECK_PREDICTED, '0},
		'{KIND_RUN,   16'h0000, 17'h00000, CHECK_NONE,      '0},
		// bins without queries: no answer
		'{KIND_BIN,   16'h1234, 17'h00000, CHECK_PREDICTED, '0},
		'{KIND_RUN,   16'h0000, 17'h00000, CHECK_NONE,      '0},
		// unsorted queries, a zero bin in the middle, exact one and a clamped one
		'{KIND_BIN,   16'h0100, 17'h00000, CHECK_PREDICTED, '0},
		'{KIND_BIN,   16'h0000, 17'h00000, CHECK_PREDICTED, '0},
		'{KIND_BIN,   16'h0300, 17'h00000, CHECK_PREDICTED, '0},
		'{KIND_QUERY, 16'h0000, 17'h10000, CHECK_PREDICTED, '0},
		'{KIND_QUERY, 16'h0000, 17'h04000, CHECK_PREDICTED, '0},
		'{KIND_QUERY, 16'h0000, 17'h00000, CHECK_PREDICTED, '0},
		'{KIND_QUERY, 16'h0000, 17'h0AAAA, CHECK_PREDICTED, '0},
		'{KIND_QUERY, 16'h0000, 17'h15555, CHECK_PREDICTED, '0},
		'{KIND_RUN,   16'h0000, 17'h00000, CHECK_PREDICTED, '0}
	};

	histogram_percentile_finder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.kind           (kind),
		.bin_weight     (bin_weight),
		.query_fraction (query_fraction),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result_value   (result_value),
		.query_rank     (query_rank),
		.overflowed     (overflowed),
		.last           (last),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#3_000_000;
		$display("Timeout at %0t with %0d answers still owed", $time, pend_wr - pend_rd);
		$display("FAIL histogram_percentile_finder");
		$finish;
	end

	// Bin index plus offset, clamped at the top of the signed 32-bit range. The
	// index is never negative, so the bottom can not be crossed.
	function automatic logic [VAL_W-1:0] offset_index(int unsigned idx);
		longint s;
		s = longint'($signed(offset_m)) + longint'(idx);
		if (s > 64'sd2147483647)
			return VAL_MAX;
		return VAL_W'(s);
	endfunction

	// Append one answer to the ring of owed answers.
	function automatic void owe_answer(answer_t a);
		pending_answers[pend_wr % PEND_DEPTH] = a;
		pend_wr++;
	endfunction

	// Advance the mirrored state by one accepted item and collect the answers
	// that a run owes.
	function automatic void predict_quantiles(logic [KIND_W-1:0] op, logic [WGT_IN_W-1:0] w,
			logic [QF_W-1:0] q);
		longint unsigned cum;
		int unsigned     idx;
		int unsigned     rank;
		int              pos;
		logic [QF_W-1:0] qc;
		answer_t         a;
		fresh_count = 0;
		case (op)
		KIND_BIN: begin
			if (nbins_m >= MAX_BINS) begin
				dropped_m = 1'b1;
			end else begin
				bins_m[nbins_m] = w[WT_W-1:0];
				nbins_m++;
				total_m += w[WT_W-1:0];
			end
		end
		KIND_QUERY: begin
			qc = (q > ONE_Q16) ? ONE_Q16 : q;
			if (nq_m >= MAX_QUERIES) begin
				dropped_m = 1'b1;
			end else begin
				// keep the list ascending: shift larger entries up by one
				pos = nq_m;
				while (pos > 0 && queries_m[pos - 1] > qc) begin
					queries_m[pos] = queries_m[pos - 1];
					pos--;
				end
				queries_m[pos] = qc;
				nq_m++;
			end
		end
		KIND_RUN: begin
			cum  = 0;
			rank = 0;
			for (idx = 0; idx < nbins_m && rank < nq_m; idx++) begin
				cum += bins_m[idx];
				while (rank < nq_m && cum * 64'd65536 >= 64'(queries_m[rank]) * total_m) begin
					a.value = offset_index(idx);
					a.rank  = RANK_W'(rank);
					a.ovf   = dropped_m;
					a.last  = 1'b0;
					fresh_answers[fresh_count] = a;
					fresh_count++;
					rank++;
				end
			end
			if (fresh_count > 0)
				fresh_answers[fresh_count - 1].last = 1'b1;
			nbins_m   = 0;
			total_m   = 0;
			nq_m      = 0;
			dropped_m = 1'b0;
		end
		default: ;
		endcase
	endfunction

	// Present one item, hold it until the transfer, then record what it owes.
	// Called and returns at a rising edge.
	task automatic send_item(logic [KIND_W-1:0] op, logic [WGT_IN_W-1:0] w, logic [QF_W-1:0] q,
			int check, answer_t want);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid     <= 1'b1;
		kind           <= op;
		bin_weight     <= w;
		query_fraction <= q;
		// stall is settled by the falling edge; the transfer happens at the next rise
		do
			@(negedge clk);
		while (item_stall);
		@(posedge clk);
		predict_quantiles(op, w, q);
		if (check == CHECK_ONE)
			owe_answer(want);
		else if (check == CHECK_PREDICTED)
			for (int i = 0; i < fresh_count; i++)
				owe_answer(fresh_answers[i]);
		if (op == KIND_SPARE)
			spare_sent++;
		else
			items_sent++;
		if (op == KIND_RUN)
			runs_sent++;
	endtask

	// Drop valid, drain every owed answer, then let a silent run finish too.
	task automatic drain_block();
		item_valid <= 1'b0;
		while (pend_wr != pend_rd)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_offset(logic [VAL_W-1:0] v);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		offset_m = v;
		offsets_used++;
	endtask

	function automatic logic [QF_W-1:0] pick_fraction();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return ONE_Q16;
		if (pick == 2)
			return QF_W'($urandom_range(131071, 65537));
		return QF_W'($urandom_range(65536));
	endfunction

	// One well-formed load sequence with random order and content, sprinkled
	// with ignored items, closed by a run.
	task automatic load_and_run(int nbins, int nqueries, int unsigned max_weight);
		int          bins_left;
		int          queries_left;
		bit          flat;
		int unsigned pick;
		logic [WGT_IN_W-1:0] w;
		bins_left    = nbins;
		queries_left = nqueries;
		flat         = ($urandom_range(19) == 0); // all weights zero
		while (bins_left + queries_left > 0) begin
			if ($urandom_range(19) == 0)
				send_item(KIND_SPARE, WGT_IN_W'($urandom), QF_W'($urandom), CHECK_PREDICTED, '0);
			if (int'($urandom_range(bins_left + queries_left - 1)) < bins_left) begin
				pick = $urandom_range(9);
				if (flat || pick == 0)
					w = '0;
				else if (pick == 1)
					w = WGT_IN_W'(max_weight);
				else
					w = WGT_IN_W'($urandom_range(max_weight));
				send_item(KIND_BIN, w, QF_W'($urandom), CHECK_PREDICTED, '0);
				bins_left--;
			end else begin
				send_item(KIND_QUERY, WGT_IN_W'($urandom), pick_fraction(), CHECK_PREDICTED, '0);
				queries_left--;
			end
		end
		send_item(KIND_RUN, WGT_IN_W'($urandom), QF_W'($urandom), CHECK_PREDICTED, '0);
	endtask

	// Mostly ordinary sessions; some overfill the query list, some lack bins or
	// queries altogether.
	task automatic random_sessions(int budget);
		int          start;
		int unsigned pick;
		start = items_sent;
		while (items_sent - start < budget) begin
			pick = $urandom_range(99);
			if (pick < 5)
				load_and_run(0, $urandom_range(1, 4), 65535);
			else if (pick < 10)
				load_and_run($urandom_range(1, 4), 0, 65535);
			else if (pick < 20)
				load_and_run($urandom_range(1, 8),
					$urandom_range(MAX_QUERIES - 1, MAX_QUERIES + 2), 65535);
			else
				load_and_run($urandom_range(1, 10), $urandom_range(1, 5), 65535);
		end
	endtask

	// Receiver side: stall at the rate of the current phase.
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic void check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Compare each answer that will transfer at the next rise with the oldest owed one.
	always @(negedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			answers_seen++;
			if (pend_wr == pend_rd) begin
				$display("%0t: unexpected answer: expected none, got value %0h rank %0d",
					$time, result_value, query_rank);
				fail_count++;
			end else begin
				head = pending_answers[pend_rd % PEND_DEPTH];
				pend_rd++;
				check_field("result_value", head.value, result_value);
				check_field("query_rank", VAL_W'(head.rank), VAL_W'(query_rank));
				check_field("overflowed", VAL_W'(head.ovf), VAL_W'(overflowed));
				check_field("last", VAL_W'(head.last), VAL_W'(last));
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i])
			send_item(directed_steps[i].op, directed_steps[i].weight, directed_steps[i].frac,
				directed_steps[i].check, directed_steps[i].want);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain_block();
			case (phase)
			0: begin
				// near the top: high bins clamp; a full histogram overfills both stores
				idle_pct  = 0;
				stall_pct = 0;
				write_offset(32'h7FFF_FF9C);
				load_and_run(MAX_BINS + 2, MAX_QUERIES + 1, 255);
			end
			1: begin
				idle_pct  = 51;
				stall_pct = 0;
				write_offset(32'h8000_0000);
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 51;
				write_offset(32'h7FFF_FFFF);
			end
			default: begin
				// small negative offset so answers cross zero
				idle_pct  = 7;
				stall_pct = 7;
				write_offset(-VAL_W'($urandom_range(1, 300)));
			end
			endcase
			random_sessions(PHASE_ITEMS);
		end
		drain_block();

		$display("Run covered %0d load and run transfers (%0d runs) plus %0d ignored items,",
			items_sent, runs_sent, spare_sent);
		$display("with %0d answers compared across %0d offset writes and four pause mixes",
			answers_seen, offsets_used);
		if (fail_count == 0)
			$display("PASS histogram_percentile_finder");
		else
			$display("FAIL histogram_percentile_finder");
		$finish;
	end

endmodule
